@@ hw/rtl/rth_pkg.sv @@
// Shared constants and types for the RGB to HSV converter.
`default_nettype none

package rth_pkg;

   localparam int COMPONENT_BITS_DEF = 8;
   localparam int HUE_BITS           = 15;
   localparam int SAT_BITS           = 16;
   localparam int QUO_BITS           = 16;
   localparam int FRONT_STAGES       = 2;
   localparam int OUT_STAGES         = 1;

   // 60 degrees in 1/64 degree steps is 3840 = 4096 - 256
   localparam int HUE_MUL_HI = 12;
   localparam int HUE_MUL_LO = 8;

   localparam logic [HUE_BITS-1:0] HUE_DEG0   = 15'd0;
   localparam logic [HUE_BITS-1:0] HUE_DEG120 = 15'd7680;
   localparam logic [HUE_BITS-1:0] HUE_DEG240 = 15'd15360;
   localparam logic [HUE_BITS-1:0] HUE_DEG360 = 15'd23040;

   // hue sector control carried alongside the hue divider
   typedef struct packed {
      logic                neg;      // offset is subtracted (round up the quotient)
      logic                dz;       // delta is zero, hue forced to zero
      logic                mz;       // max is zero, saturation forced to zero
      logic [HUE_BITS-1:0] base;     // sector base angle
   } hue_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/rgb_to_hsv.sv @@
// Top level of the RGB to HSV pixel converter.
//
//   channel  prefix  direction  handshake        payload
//   input    req_    in         valid / stall    red, green, blue
//   result   rsp_    out        valid / stall    hue, saturation, brightness
//
// One pixel per clock sustained while rsp_stall is low; pipeline stages:
// 2 front stages (extremes, numerators), 16 divider stages (one quotient
// bit each, hue and saturation dividers side by side), 1 output stage.
// Synchronous active-high reset clears the stage valid bits only.
// Each stage holds while it is full and the stage after it cannot take its
// transaction; empty stages keep filling, so bubbles collapse under a stall.
`default_nettype none

module rgb_to_hsv #(
   parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [COMPONENT_BITS-1:0]     req_red,
   input  wire logic [COMPONENT_BITS-1:0]     req_green,
   input  wire logic [COMPONENT_BITS-1:0]     req_blue,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [rth_pkg::HUE_BITS-1:0]  rsp_hue,
   output      logic [rth_pkg::SAT_BITS-1:0]  rsp_saturation,
   output      logic [COMPONENT_BITS-1:0]     rsp_brightness
);
   import rth_pkg::*;

   localparam int CB   = COMPONENT_BITS;
   localparam int HNW  = CB + HUE_MUL_HI;
   localparam int SNW  = CB + SAT_BITS;
   localparam int CTLW = $bits(hue_ctl_type);
   localparam int NSTG = FRONT_STAGES + QUO_BITS + OUT_STAGES;
   localparam int DIV0 = FRONT_STAGES;
   localparam int OUTS = FRONT_STAGES + QUO_BITS;

   // per-stage valid bits and load enables
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] en;

   // a stage loads when any stage from it to the output is empty,
   // or the output is being taken
   for (genvar i = 0; i < NSTG; i++) begin : g_en
      localparam logic [NSTG-1:0] UPPER = {NSTG{1'b1}} << i;
      assign en[i] = !rsp_stall || (((~v_ff) & UPPER) != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= (i == 0) ? req_valid : v_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NSTG-1];

   // front end
   logic [HNW-1:0] hue_num;
   logic [CB-1:0]  hue_den;
   logic [SNW-1:0] sat_num;
   logic [CB-1:0]  sat_den;
   hue_ctl_type    ctl_f, ctl_d;
   logic [CTLW-1:0] ctl_bits;

   rth_front #(
      .COMPONENT_BITS(CB)
   ) u_front (
      .clock   (clock),
      .en      (en[FRONT_STAGES-1:0]),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .hue_num (hue_num),
      .hue_den (hue_den),
      .sat_num (sat_num),
      .sat_den (sat_den),
      .ctl     (ctl_f)
   );

   // hue offset divider: 3840*d / delta, sector control rides along
   logic [QUO_BITS-1:0] hue_quo;
   logic                hue_rem_nz;

   rth_div #(
      .NW(HNW),
      .DW(CB),
      .QW(QUO_BITS),
      .SW(CTLW)
   ) u_hue_div (
      .clock  (clock),
      .en     (en[OUTS-1:DIV0]),
      .num    (hue_num),
      .den    (hue_den),
      .side_i (ctl_f),
      .quo    (hue_quo),
      .rem_nz (hue_rem_nz),
      .side_o (ctl_bits)
   );

   assign ctl_d = hue_ctl_type'(ctl_bits);

   // saturation divider: 65535*delta / max, brightness rides along
   logic [QUO_BITS-1:0] sat_quo;
   logic [CB-1:0]       bright_d;

   rth_div #(
      .NW(SNW),
      .DW(CB),
      .QW(QUO_BITS),
      .SW(CB)
   ) u_sat_div (
      .clock  (clock),
      .en     (en[OUTS-1:DIV0]),
      .num    (sat_num),
      .den    (sat_den),
      .side_i (sat_den),
      .quo    (sat_quo),
      .rem_nz (),
      .side_o (bright_d)
   );

   // result register
   rth_out #(
      .COMPONENT_BITS(CB)
   ) u_out (
      .clock      (clock),
      .en         (en[OUTS]),
      .hue_quo    (hue_quo),
      .hue_rem_nz (hue_rem_nz),
      .ctl        (ctl_d),
      .sat_quo    (sat_quo),
      .bright     (bright_d),
      .hue        (rsp_hue),
      .saturation (rsp_saturation),
      .brightness (rsp_brightness)
   );

endmodule

`default_nettype wire

@@ hw/rtl/rth_front.sv @@
// Front stages: max/min/sector decode, then divider numerators.
`default_nettype none

module rth_front #(
   parameter int COMPONENT_BITS = 8
) (
   input  wire logic                                          clock,
   input  wire logic [1:0]                                    en,
   input  wire logic [COMPONENT_BITS-1:0]                     red,
   input  wire logic [COMPONENT_BITS-1:0]                     green,
   input  wire logic [COMPONENT_BITS-1:0]                     blue,
   output      logic [COMPONENT_BITS+rth_pkg::HUE_MUL_HI-1:0] hue_num,
   output      logic [COMPONENT_BITS-1:0]                     hue_den,
   output      logic [COMPONENT_BITS+rth_pkg::SAT_BITS-1:0]   sat_num,
   output      logic [COMPONENT_BITS-1:0]                     sat_den,
   output      rth_pkg::hue_ctl_type                          ctl
);
   import rth_pkg::*;

   localparam int CB  = COMPONENT_BITS;
   localparam int HNW = CB + HUE_MUL_HI;
   localparam int SNW = CB + SAT_BITS;

   logic [CB-1:0]       mx_in, mn_in, d_in;
   logic                neg_in;
   logic [HUE_BITS-1:0] base_in;

   logic [CB-1:0]       mx_ff, delta_ff, d_ff;
   logic                neg_ff;
   logic [HUE_BITS-1:0] base_ff;

   logic [HNW-1:0]      hue_num_in, hue_num_ff;
   logic [SNW-1:0]      sat_num_in, sat_num_ff;
   logic [CB-1:0]       hue_den_ff, sat_den_ff;
   hue_ctl_type         ctl_in, ctl_ff;

   // stage 0: extremes and sector
   always_comb begin
      mx_in = (red > green) ? red : green;
      mx_in = (mx_in > blue) ? mx_in : blue;
      mn_in = (red < green) ? red : green;
      mn_in = (mn_in < blue) ? mn_in : blue;
      if (red >= green && red >= blue) begin
         if (green >= blue) begin
            base_in = HUE_DEG0;
            d_in    = green - blue;
            neg_in  = 1'b0;
         end else begin
            base_in = HUE_DEG360;
            d_in    = blue - green;
            neg_in  = 1'b1;
         end
      end else if (green >= blue) begin
         base_in = HUE_DEG120;
         neg_in  = (blue < red);
         d_in    = neg_in ? (red - blue) : (blue - red);
      end else begin
         base_in = HUE_DEG240;
         neg_in  = (red < green);
         d_in    = neg_in ? (green - red) : (red - green);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mx_ff    <= mx_in;
         delta_ff <= mx_in - mn_in;
         d_ff     <= d_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
      end
   end

   // stage 1: numerators, 3840*d and 65535*delta by shift and subtract
   always_comb begin
      hue_num_in = (HNW'(d_ff) << HUE_MUL_HI) - (HNW'(d_ff) << HUE_MUL_LO);
      sat_num_in = (SNW'(delta_ff) << SAT_BITS) - SNW'(delta_ff);
      ctl_in.neg  = neg_ff;
      ctl_in.dz   = (delta_ff == '0);
      ctl_in.mz   = (mx_ff == '0);
      ctl_in.base = base_ff;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hue_num_ff <= hue_num_in;
         sat_num_ff <= sat_num_in;
         hue_den_ff <= delta_ff;
         sat_den_ff <= mx_ff;
         ctl_ff     <= ctl_in;
      end
   end

   assign hue_num = hue_num_ff;
   assign hue_den = hue_den_ff;
   assign sat_num = sat_num_ff;
   assign sat_den = sat_den_ff;
   assign ctl     = ctl_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rth_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module rth_div #(
   parameter int NW = 20,
   parameter int DW = 8,
   parameter int QW = 16,
   parameter int SW = 8
) (
   input  wire logic          clock,
   input  wire logic [QW-1:0] en,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   input  wire logic [SW-1:0] side_i,
   output      logic [QW-1:0] quo,
   output      logic          rem_nz,
   output      logic [SW-1:0] side_o
);

   // numerator is known to be below den * 2**QW
   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [NW-1:0] rem_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int SH = QW - 1 - k;

      logic [NW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] quo_src;
      logic [SW-1:0] side_src;
      logic [CW-1:0] rem_wide, den_wide;
      logic          ge;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_src  = num;
         assign den_src  = den;
         assign quo_src  = '0;
         assign side_src = side_i;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign rem_wide = CW'(rem_src);
      assign den_wide = CW'(den_src) << SH;
      assign ge       = (rem_wide >= den_wide);
      assign rem_in   = ge ? NW'(rem_wide - den_wide) : rem_src;
      assign quo_in   = {quo_src[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign quo    = quo_ff[QW-1];
   assign rem_nz = |rem_ff[QW-1];
   assign side_o = side_ff[QW-1];

endmodule

`default_nettype wire

@@ hw/rtl/rth_out.sv @@
// Output stage: hue sector correction and special cases, result registers.
`default_nettype none

module rth_out #(
   parameter int COMPONENT_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [rth_pkg::QUO_BITS-1:0]  hue_quo,
   input  wire logic                          hue_rem_nz,
   input  wire rth_pkg::hue_ctl_type          ctl,
   input  wire logic [rth_pkg::QUO_BITS-1:0]  sat_quo,
   input  wire logic [COMPONENT_BITS-1:0]     bright,
   output      logic [rth_pkg::HUE_BITS-1:0]  hue,
   output      logic [rth_pkg::SAT_BITS-1:0]  saturation,
   output      logic [COMPONENT_BITS-1:0]     brightness
);
   import rth_pkg::*;

   localparam int SW = QUO_BITS + 1;

   logic [SW-1:0]             hsum;
   logic [HUE_BITS-1:0]       hue_in, hue_ff;
   logic [SAT_BITS-1:0]       sat_in, sat_ff;
   logic [COMPONENT_BITS-1:0] bright_ff;

   // falling sectors take the ceiling of the offset
   always_comb begin
      if (ctl.neg) begin
         hsum = SW'(ctl.base) - SW'(hue_quo) - SW'(hue_rem_nz);
      end else begin
         hsum = SW'(ctl.base) + SW'(hue_quo);
      end
      hue_in = ctl.dz ? '0 : hsum[HUE_BITS-1:0];
      sat_in = ctl.mz ? '0 : sat_quo[SAT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= bright;
      end
   end

   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign brightness = bright_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rth_chk.sv @@
// Port-level checker for the RGB to HSV converter, bound to the top level.
`default_nettype none

module rth_chk #(
   parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [rth_pkg::HUE_BITS-1:0]  rsp_hue,
   input wire logic [rth_pkg::SAT_BITS-1:0]  rsp_saturation,
   input wire logic [COMPONENT_BITS-1:0]     rsp_brightness
);
   import rth_pkg::*;

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // with the output draining, every stage can move
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hue)
         && $stable(rsp_saturation) && $stable(rsp_brightness))
      else $error("stalled result changed");

   // hue stays below a full turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue < HUE_DEG360)
      else $error("hue out of range");

   // a result with zero saturation (gray or black) has no hue
   a_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_saturation == '0) |-> (rsp_hue == '0))
      else $error("hue set on a gray pixel");

endmodule

bind rgb_to_hsv rth_chk #(.COMPONENT_BITS(COMPONENT_BITS)) u_rth_chk (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the rgb_to_hsv pixel converter.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rth_pkg::*;

   localparam int PIX_BITS    = COMPONENT_BITS_DEF;
   localparam int PERIOD      = 10;
   localparam int HOLD_CYCLES = 120;   // long output hold-off, well past pipeline depth
   localparam int TAIL_CYCLES = 40;    // settle time after the last result
   localparam int QUIET_LIMIT = 2000;  // cycles with no transaction on either channel

   // hue constants in 1/64 degree steps
   localparam int unsigned DEG60  = 3840;
   localparam int unsigned DEG120 = 7680;
   localparam int unsigned DEG240 = 15360;
   localparam int unsigned DEG360 = 23040;

   typedef logic [PIX_BITS-1:0] pix_type;

   typedef struct packed {
      logic [HUE_BITS-1:0] hue;
      logic [SAT_BITS-1:0] sat;
      pix_type             val;
   } hsv_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   pix_type             req_red = '0;
   pix_type             req_green = '0;
   pix_type             req_blue = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [HUE_BITS-1:0] rsp_hue;
   logic [SAT_BITS-1:0] rsp_saturation;
   pix_type             rsp_brightness;

   hsv_type hsv_pending[$];   // expected conversions, oldest first
   int   pixels_sent = 0;
   int   pixels_checked = 0;
   int   mismatch_count = 0;
   int   quiet_cycles = 0;

   bit   send_idle_on = 1'b1;   // sender gaps, used only by the stimulus process
   bit   recv_idle_on = 1'b1;   // receiver stalls, written with <= from the stimulus
   int   hold_req = 0;          // bumped to ask the receiver for one long hold-off
   int   hold_ack = 0;
   int   hold_left = 0;

   rgb_to_hsv DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   always #(PERIOD/2) clock = ~clock;

   // ------------------------------------------------------------------
   // Expected HSV of one pixel. Exact integer math: hue numerator is
   // sector base * delta plus or minus 60 deg * difference, so the
   // truncating divide matches a floor of the real-valued hue.
   // ------------------------------------------------------------------
   function automatic hsv_type hsv_of_pixel(pix_type r, pix_type g, pix_type b);
      int unsigned ru, gu, bu, mx, mn, delta, num;
      hsv_type     res;
      ru = r;
      gu = g;
      bu = b;
      mx = (ru > gu) ? ru : gu;
      mx = (mx > bu) ? mx : bu;
      mn = (ru < gu) ? ru : gu;
      mn = (mn < bu) ? mn : bu;
      delta = mx - mn;
      num = 0;
      // red wins ties over green, green over blue
      if (delta == 0)
         num = 0;
      else if (ru >= mx) begin
         if (gu >= bu)
            num = DEG60 * (gu - bu);
         else
            num = DEG360 * delta - DEG60 * (bu - gu);   // negative hue wraps
      end else if (gu >= mx) begin
         if (bu >= ru)
            num = DEG120 * delta + DEG60 * (bu - ru);
         else
            num = DEG120 * delta - DEG60 * (ru - bu);
      end else begin
         if (ru >= gu)
            num = DEG240 * delta + DEG60 * (ru - gu);
         else
            num = DEG240 * delta - DEG60 * (gu - ru);
      end
      res.hue = (delta == 0) ? '0 : HUE_BITS'(num / delta);
      res.sat = (mx == 0) ? '0 : SAT_BITS'((delta * 65535) / mx);   // black gives zero
      res.val = pix_type'(mx);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= recv_idle_on && ($urandom_range(0, 99) < 10);
      end
   end

   // ------------------------------------------------------------------
   // Result checker: every result transaction against the oldest
   // expectation. Inputs were sampled before this edge's updates.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      hsv_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hsv_pending.size() == 0) begin
            $error("unexpected result: hue %0d saturation %0d brightness %0d",
                   rsp_hue, rsp_saturation, rsp_brightness);
            mismatch_count++;
         end else begin
            want = hsv_pending.pop_front();
            pixels_checked++;
            if (rsp_hue !== want.hue) begin
               $error("hue mismatch: expected %0d, actual %0d", want.hue, rsp_hue);
               mismatch_count++;
            end
            if (rsp_saturation !== want.sat) begin
               $error("saturation mismatch: expected %0d, actual %0d",
                      want.sat, rsp_saturation);
               mismatch_count++;
            end
            if (rsp_brightness !== want.val) begin
               $error("brightness mismatch: expected %0d, actual %0d",
                      want.val, rsp_brightness);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a stretch with no transaction on either side means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, hsv_pending.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sender side.
   // ------------------------------------------------------------------

   // Offer one pixel and hold it until the block takes the transaction.
   // Valid stays high between back-to-back pixels.
   task automatic send_pixel(input pix_type r, input pix_type g, input pix_type b);
      int gap;
      if (send_idle_on && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hsv_pending.push_back(hsv_of_pixel(r, g, b));
      pixels_sent++;
   endtask

   // Drop valid and wait until every outstanding result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (hsv_pending.size() != 0);
   endtask

   // Pixel from one of several clusters that hit ties, grays and extremes.
   task automatic send_clustered_pixel();
      pix_type c[3];
      pix_type m;
      int      k;
      case ($urandom_range(0, 5))
         0: begin   // gray: all equal
            m = pix_type'($urandom);
            c[0] = m; c[1] = m; c[2] = m;
         end
         1: begin   // two components tie for max
            m = pix_type'($urandom);
            k = $urandom_range(0, 2);
            c[0] = m; c[1] = m; c[2] = m;
            c[k] = pix_type'($urandom_range(0, m));
         end
         2: begin   // tiny delta
            m = pix_type'($urandom_range(2, 253));
            for (int i = 0; i < 3; i++)
               c[i] = m + pix_type'($urandom_range(0, 4)) - pix_type'(2);
         end
         3: begin   // components pinned at the rails
            for (int i = 0; i < 3; i++) begin
               k = $urandom_range(0, 2);
               c[i] = (k == 0) ? '0 : (k == 1) ? '1 : pix_type'($urandom);
            end
         end
         4: begin   // near black
            for (int i = 0; i < 3; i++)
               c[i] = pix_type'($urandom_range(0, 3));
         end
         default: begin
            for (int i = 0; i < 3; i++)
               c[i] = pix_type'($urandom);
         end
      endcase
      send_pixel(c[0], c[1], c[2]);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Corners: black, white, primaries, every sector both ways, ties.
   task automatic test_corner_pixels();
      send_pixel(8'd0,   8'd0,   8'd0);     // black: sat and hue zero
      send_pixel(8'd255, 8'd255, 8'd255);   // white: equal components
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0,   8'd0);     // pure red
      send_pixel(8'd0,   8'd255, 8'd0);     // pure green
      send_pixel(8'd0,   8'd0,   8'd255);   // pure blue
      send_pixel(8'd255, 8'd255, 8'd0);     // red/green tie, red wins
      send_pixel(8'd0,   8'd255, 8'd255);   // green/blue tie, green wins
      send_pixel(8'd255, 8'd0,   8'd255);   // red/blue tie, red wins, hue wraps
      send_pixel(8'd255, 8'd1,   8'd0);     // red max, small positive hue
      send_pixel(8'd255, 8'd0,   8'd1);     // red max, negative hue wraps near 360
      send_pixel(8'd255, 8'd254, 8'd254);   // delta one at max
      send_pixel(8'd0,   8'd255, 8'd1);     // green max, blue above red
      send_pixel(8'd1,   8'd255, 8'd0);     // green max, red above blue
      send_pixel(8'd1,   8'd0,   8'd255);   // blue max, red above green
      send_pixel(8'd0,   8'd1,   8'd255);   // blue max, green above red
      send_pixel(8'd1,   8'd0,   8'd0);     // smallest non-black
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd170, 8'd85,  8'd0);
      send_pixel(8'd85,  8'd170, 8'd255);
      wait_for_results();
   endtask

   // Uniform random colors with random gaps and stalls.
   task automatic test_uniform_pixels(input int count);
      for (int i = 0; i < count; i++)
         send_pixel(pix_type'($urandom), pix_type'($urandom), pix_type'($urandom));
      wait_for_results();
   endtask

   // Clustered colors aimed at ties, grays and rails.
   task automatic test_clustered_pixels(input int count);
      for (int i = 0; i < count; i++)
         send_clustered_pixel();
      wait_for_results();
   endtask

   // Full rate: no gaps from either side, one pixel per clock.
   task automatic test_full_rate(input int count);
      send_idle_on = 1'b0;
      recv_idle_on <= 1'b0;
      for (int i = 0; i < count; i++)
         send_clustered_pixel();
      send_idle_on = 1'b1;
      recv_idle_on <= 1'b1;
      wait_for_results();
   endtask

   // Output held off long enough to fill the pipe and stall the input,
   // sender keeps offering throughout; then a full drain before more.
   task automatic test_backpressure(input int during_hold, input int after);
      send_idle_on = 1'b0;
      hold_req <= hold_req + 1;
      for (int i = 0; i < during_hold; i++)
         send_pixel(pix_type'($urandom), pix_type'($urandom), pix_type'($urandom));
      send_idle_on = 1'b1;
      wait_for_results();
      for (int i = 0; i < after; i++)
         send_clustered_pixel();
      wait_for_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_corner_pixels();
      test_uniform_pixels(700);
      test_clustered_pixels(500);
      test_full_rate(300);
      test_backpressure(80, 250);

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d pixels (%0d checked): corners, uniform and clustered colors,",
               pixels_sent, pixels_checked);
      $display("random gaps and stalls, a full-rate run and a %0d-cycle output hold-off.",
               HOLD_CYCLES);
      if (mismatch_count == 0 && hsv_pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatch_count, hsv_pending.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/rth_pkg.sv
hw/rtl/rth_front.sv
hw/rtl/rth_div.sv
hw/rtl/rth_out.sv
hw/rtl/rgb_to_hsv.sv
hw/rtl/rth_chk.sv
bench/testbench.sv
